[sv/tmr_pkg.sv]
// tmr_pkg: shared types and constants of the turing machine runner
// no dependencies; imported by every module of the block
`default_nettype none

package tmr_pkg;

   // sizes
   localparam int SYM_BITS       = 8;
   localparam int STATE_BITS     = 4;
   localparam int TAPE_CELLS     = 1024;
   localparam int TAPE_ADDR_BITS = $clog2(TAPE_CELLS);
   localparam int TAPE_LEN_BITS  = TAPE_ADDR_BITS + 1;
   localparam int STEP_BITS      = 21;
   localparam int MOVE_BITS      = 2;
   localparam int KIND_BITS      = 2;
   localparam int OUTCOME_BITS   = 3;
   localparam int TBL_ADDR_BITS  = STATE_BITS + SYM_BITS;
   localparam int TBL_DEPTH      = 1 << TBL_ADDR_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = STEP_BITS;
   localparam int REQ_DATA_BITS  = 40;
   localparam int RSP_DATA_BITS  = 48;

   localparam logic [TAPE_LEN_BITS-1:0] TAPE_CELLS_LEN = TAPE_LEN_BITS'(TAPE_CELLS);

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_RUN   = 2'd3;

   // head moves
   localparam logic [MOVE_BITS-1:0] MOVE_LEFT  = 2'd0;
   localparam logic [MOVE_BITS-1:0] MOVE_RIGHT = 2'd1;

   // run outcomes
   localparam logic [OUTCOME_BITS-1:0] END_ACCEPT = 3'd0;
   localparam logic [OUTCOME_BITS-1:0] END_RIGHT  = 3'd1;
   localparam logic [OUTCOME_BITS-1:0] END_LEFT   = 3'd2;
   localparam logic [OUTCOME_BITS-1:0] END_NONE   = 3'd3;
   localparam logic [OUTCOME_BITS-1:0] END_LIMIT  = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_STATE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEPT_STATE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAPE_LENGTH  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_LIMIT   = 2'd3;

   // register reset values
   localparam logic [STATE_BITS-1:0]    START_STATE_RST  = 4'd0;
   localparam logic [STATE_BITS-1:0]    ACCEPT_STATE_RST = 4'd15;
   localparam logic [TAPE_LEN_BITS-1:0] TAPE_LENGTH_RST  = 11'd0;
   localparam logic [STEP_BITS-1:0]     STEP_LIMIT_RST   = 21'd65536;

   typedef struct packed {
      logic                  valid;
      logic [STATE_BITS-1:0] next_state;
      logic [SYM_BITS-1:0]   write_char;
      logic [MOVE_BITS-1:0]  head_move;
   } rule_type;

   typedef struct packed {
      logic [STATE_BITS-1:0]    start_state;
      logic [STATE_BITS-1:0]    accept_state;
      logic [TAPE_LEN_BITS-1:0] tape_length;
      logic [STEP_BITS-1:0]     step_limit;
   } cfg_type;

   typedef struct packed {
      logic                      rd_en;
      logic [TAPE_ADDR_BITS-1:0] rd_addr;
      logic                      wr_en;
      logic [TAPE_ADDR_BITS-1:0] wr_addr;
      logic [SYM_BITS-1:0]       wr_data;
   } tape_port_type;

   typedef struct packed {
      logic                     rd_en;
      logic [TBL_ADDR_BITS-1:0] rd_addr;
      logic                     wr_en;
      logic [TBL_ADDR_BITS-1:0] wr_addr;
      rule_type                 wr_data;
   } tbl_port_type;

endpackage

`default_nettype wire

[sv/tmr_tape_ram.sv]
// tmr_tape_ram: tape cell memory, one write and one registered read per cycle
// depends on tmr_pkg
`default_nettype none

module tmr_tape_ram (
   input  wire                              clock,
   input  tmr_pkg::tape_port_type           port,
   output logic [tmr_pkg::SYM_BITS-1:0]     rd_data
);
   import tmr_pkg::*;

   logic [SYM_BITS-1:0] cells_ff [TAPE_CELLS];
   logic [SYM_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         cells_ff[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= cells_ff[port.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/tmr_rule_ram.sv]
// tmr_rule_ram: transition table memory keyed by state and symbol
// depends on tmr_pkg
`default_nettype none

module tmr_rule_ram (
   input  wire                    clock,
   input  tmr_pkg::tbl_port_type  port,
   output tmr_pkg::rule_type      rd_data
);
   import tmr_pkg::*;

   rule_type rules_ff [TBL_DEPTH];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         rules_ff[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= rules_ff[port.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/tmr_ctrl.sv]
// tmr_ctrl: item decode, table clearing sweep, machine step sequencer, result register
// depends on tmr_pkg; drives tmr_tape_ram and tmr_rule_ram
`default_nettype none

module tmr_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  tmr_pkg::cfg_type                    cfg,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [tmr_pkg::KIND_BITS-1:0]       req_tuser,
   input  wire  [tmr_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [tmr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output tmr_pkg::tape_port_type              tape_port,
   input  wire  [tmr_pkg::SYM_BITS-1:0]        tape_rd_data,
   output tmr_pkg::tbl_port_type               tbl_port,
   input  tmr_pkg::rule_type                   tbl_rd_data
);
   import tmr_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_RDWAIT = 3'd2;
   localparam logic [2:0] ST_TREAD  = 3'd3;
   localparam logic [2:0] ST_LOOKUP = 3'd4;
   localparam logic [2:0] ST_EXEC   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [TBL_ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [STATE_BITS-1:0]     mstate_ff, mstate_in;
   logic [TAPE_ADDR_BITS-1:0] head_ff, head_in;
   logic [STEP_BITS-1:0]      steps_ff, steps_in;
   logic [TAPE_LEN_BITS-1:0]  len_ff, len_in;
   logic [OUTCOME_BITS-1:0]   outcome_ff, outcome_in;
   logic [SYM_BITS-1:0]       cell_ff, cell_in;
   logic                      fwd_ff, fwd_in;
   logic [SYM_BITS-1:0]       fwd_sym_ff, fwd_sym_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;

   // request fields, lowest bits first
   logic [STATE_BITS-1:0]     req_from;
   logic [SYM_BITS-1:0]       req_rchar;
   logic [STATE_BITS-1:0]     req_next;
   logic [SYM_BITS-1:0]       req_wchar;
   logic [MOVE_BITS-1:0]      req_move;
   logic [TAPE_ADDR_BITS-1:0] req_index;

   logic [SYM_BITS-1:0]       head_sym;
   logic [TAPE_LEN_BITS-1:0]  run_len;
   logic [TAPE_LEN_BITS-1:0]  head_plus;
   logic [TAPE_ADDR_BITS-1:0] next_head;

   assign req_from  = req_tdata[3:0];
   assign req_rchar = req_tdata[11:4];
   assign req_next  = req_tdata[15:12];
   assign req_wchar = req_tdata[23:16];
   assign req_move  = req_tdata[25:24];
   assign req_index = req_tdata[35:26];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // symbol under the head; a stay move reads the cell it wrote the cycle before
   assign head_sym  = fwd_ff ? fwd_sym_ff : tape_rd_data;
   assign run_len   = (cfg.tape_length > TAPE_CELLS_LEN) ? TAPE_CELLS_LEN : cfg.tape_length;
   assign head_plus = {1'b0, head_ff} + TAPE_LEN_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      mstate_in    = mstate_ff;
      head_in      = head_ff;
      steps_in     = steps_ff;
      len_in       = len_ff;
      outcome_in   = outcome_ff;
      cell_in      = cell_ff;
      fwd_in       = fwd_ff;
      fwd_sym_in   = fwd_sym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      next_head    = head_ff;
      tape_port    = '0;
      tbl_port     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_port.wr_en   = 1'b1;
            tbl_port.wr_addr = clr_addr_ff;
            tbl_port.wr_data = '0;
            clr_addr_in      = clr_addr_ff + TBL_ADDR_BITS'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  KIND_LOAD: begin
                     tbl_port.wr_en              = 1'b1;
                     tbl_port.wr_addr            = {req_from, req_rchar};
                     tbl_port.wr_data.valid      = 1'b1;
                     tbl_port.wr_data.next_state = req_next;
                     tbl_port.wr_data.write_char = req_wchar;
                     tbl_port.wr_data.head_move  = req_move;
                  end
                  KIND_WRITE: begin
                     tape_port.wr_en   = 1'b1;
                     tape_port.wr_addr = req_index;
                     tape_port.wr_data = req_wchar;
                  end
                  KIND_READ: begin
                     tape_port.rd_en   = 1'b1;
                     tape_port.rd_addr = req_index;
                     state_in          = ST_RDWAIT;
                  end
                  KIND_RUN: begin
                     mstate_in  = cfg.start_state;
                     head_in    = '0;
                     steps_in   = '0;
                     len_in     = run_len;
                     cell_in    = '0;
                     outcome_in = END_RIGHT;
                     // empty tape ends at once
                     state_in   = (run_len == '0) ? ST_FINISH : ST_TREAD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RDWAIT: begin
            cell_in    = tape_rd_data;
            outcome_in = '0;
            steps_in   = '0;
            head_in    = '0;
            mstate_in  = '0;
            state_in   = ST_FINISH;
         end
         ST_TREAD: begin
            tape_port.rd_en   = 1'b1;
            tape_port.rd_addr = head_ff;
            fwd_in            = 1'b0;
            state_in          = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (steps_ff >= cfg.step_limit) begin
               outcome_in = END_LIMIT;
               state_in   = ST_FINISH;
            end else begin
               tbl_port.rd_en   = 1'b1;
               tbl_port.rd_addr = {mstate_ff, head_sym};
               state_in         = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!tbl_rd_data.valid) begin
               outcome_in = END_NONE;
               state_in   = ST_FINISH;
            end else begin
               steps_in  = steps_ff + STEP_BITS'(1);
               mstate_in = tbl_rd_data.next_state;
               if (tbl_rd_data.next_state == cfg.accept_state) begin
                  outcome_in = END_ACCEPT;
                  state_in   = ST_FINISH;
               end else begin
                  tape_port.wr_en   = 1'b1;
                  tape_port.wr_addr = head_ff;
                  tape_port.wr_data = tbl_rd_data.write_char;
                  state_in          = ST_LOOKUP;
                  unique case (tbl_rd_data.head_move)
                     MOVE_LEFT: begin
                        if (head_ff == '0) begin
                           outcome_in = END_LEFT;
                           state_in   = ST_FINISH;
                        end else begin
                           next_head = head_ff - TAPE_ADDR_BITS'(1);
                        end
                     end
                     MOVE_RIGHT: begin
                        if (head_plus >= len_ff) begin
                           outcome_in = END_RIGHT;
                           next_head  = TAPE_ADDR_BITS'(len_ff - TAPE_LEN_BITS'(1));
                           state_in   = ST_FINISH;
                        end else begin
                           next_head = head_plus[TAPE_ADDR_BITS-1:0];
                        end
                     end
                     default: next_head = head_ff;
                  endcase
                  head_in = next_head;
                  if (state_in == ST_LOOKUP) begin
                     // next step's cell read overlaps this step's write
                     tape_port.rd_en   = 1'b1;
                     tape_port.rd_addr = next_head;
                     fwd_in            = (next_head == head_ff);
                     fwd_sym_in        = tbl_rd_data.write_char;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, cell_ff, mstate_ff, head_ff, steps_ff, outcome_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mstate_ff   <= mstate_in;
      head_ff     <= head_in;
      steps_ff    <= steps_in;
      len_ff      <= len_in;
      outcome_ff  <= outcome_in;
      cell_ff     <= cell_in;
      fwd_sym_ff  <= fwd_sym_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_fwd_on_overlap: assert property (@(posedge clock) disable iff (reset)
      (tape_port.wr_en && tape_port.rd_en && (tape_port.wr_addr == tape_port.rd_addr))
      |=> fwd_ff)
      else $error("tape read of a cell being written without forwarding");

   a_head_on_tape: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> ({1'b0, head_ff} < len_ff))
      else $error("head outside the tape during a step");

   a_exec_after_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> ($past(state_ff) == ST_LOOKUP))
      else $error("rule evaluated without a table read");

   a_clear_full_sweep: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) && (state_in == ST_IDLE)) |-> (&clr_addr_ff))
      else $error("table clearing ended early");
`endif

endmodule

`default_nettype wire

[sv/turing_machine_runner_top.sv]
// turing_machine_runner_top: configuration registers, tape and rule memories, sequencer
// depends on tmr_pkg, tmr_tape_ram, tmr_rule_ram, tmr_ctrl
//
//   channel | direction | role
//   req_*   | in        | items: load rule, write cell, read cell, run
//   rsp_*   | out       | one result per read or run item
//   csr_*   | in        | register writes: start, accept, tape length, step limit
//
// after reset the rule table is swept clear, all 4096 entries, with req_tready low
// load and write items are done at the transfer; a read result is registered in RDWAIT,
// then in FINISH into the output register; a run result reaches FINISH at once for an
// empty tape, from LOOKUP at the step limit, from EXEC at accept, tape edge or no rule
// each step is a rule memory read then the tape write, the next cell read overlapping the write
// a run or read holds req_tready low until its result enters the output register
`default_nettype none

module turing_machine_runner_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [1:0]   req_tuser,   // kind
   input  wire  [39:0]  req_tdata,   // from_state, read_char, next_state, write_char,
                                     // head_move, cell_index, zero fill
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [47:0]  rsp_tdata,   // outcome, steps_taken, final_head, final_state,
                                     // cell_value, zero fill
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [1:0]   csr_index,
   input  wire  [20:0]  csr_data
);
   import tmr_pkg::*;

   cfg_type       cfg_ff;
   tape_port_type tape_port;
   tbl_port_type  tbl_port;
   logic [SYM_BITS-1:0] tape_rd_data;
   rule_type      tbl_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_state  <= START_STATE_RST;
         cfg_ff.accept_state <= ACCEPT_STATE_RST;
         cfg_ff.tape_length  <= TAPE_LENGTH_RST;
         cfg_ff.step_limit   <= STEP_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_STATE:  cfg_ff.start_state  <= csr_data[STATE_BITS-1:0];
            CSR_ACCEPT_STATE: cfg_ff.accept_state <= csr_data[STATE_BITS-1:0];
            CSR_TAPE_LENGTH:  cfg_ff.tape_length  <= csr_data[TAPE_LEN_BITS-1:0];
            CSR_STEP_LIMIT:   cfg_ff.step_limit   <= csr_data[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   tmr_tape_ram u_tape (
      .clock   (clock),
      .port    (tape_port),
      .rd_data (tape_rd_data)
   );

   tmr_rule_ram u_rules (
      .clock   (clock),
      .port    (tbl_port),
      .rd_data (tbl_rd_data)
   );

   tmr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .tape_port    (tape_port),
      .tape_rd_data (tape_rd_data),
      .tbl_port     (tbl_port),
      .tbl_rd_data  (tbl_rd_data)
   );

endmodule

`default_nettype wire
